FILE: design/closest_point_on_triangle_top_defines.svh
// Assertion macros for the checker file of the closest point block.
`ifndef CLOSEST_POINT_ON_TRIANGLE_TOP_DEFINES_SVH
`define CLOSEST_POINT_ON_TRIANGLE_TOP_DEFINES_SVH

// Property checked at every rising clock edge outside reset.
`define CPT_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Condition that must hold on the edge after a reset edge.
`define CPT_ASSERT_RESET(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) reset |=> (cond)) else $error(msg);

`endif

FILE: design/cpt_pkg.sv
// Shared constants and types of the closest point on triangle block.
package cpt_pkg;

   localparam int COORD_WIDTH = 24;
   localparam int NUM_AXES    = 3;

   // pipeline depths of the sub-blocks
   localparam int MUL_LAT    = 2;
   localparam int DOTS_LAT   = 3;
   localparam int REGION_LAT = MUL_LAT + 3;
   localparam int BLEND_LAT  = MUL_LAT + 1;

   typedef enum logic [1:0] {
      RGN_INNER,
      RGN_S_EDGE,
      RGN_T_EDGE,
      RGN_HYP
   } region_type;

endpackage

FILE: design/closest_point_on_triangle_top.sv
// Top level of the closest point on triangle pipeline.
//
// Usage: one transfer on the req_ channel carries a triangle (three vertices)
// and a query point, all signed fixed point in COORD_WIDTH bits. One transfer
// on the rsp_ channel returns the point of the triangle nearest the query,
// saturated to the coordinate range. Results come back in request order.
//
// Throughput: one request per cycle, sustained, with rsp_ready held high.
// The rounding divide is a restoring divider that resolves one quotient bit
// per stage (COORD_WIDTH+2 stages); it sits behind eleven stages of edge/dot
// products, the split multipliers for the determinant terms, the region
// select/clamp and the blend products.
//
// Stall: the whole pipeline advances on one enable. The output register is
// backed by a one-entry skid buffer, so while a result waits on rsp_ready
// the pipeline keeps moving until a result lands in the skid entry; req_ready
// drops only once the skid entry is occupied, and nothing in flight is dropped or repeated.
//
// Reset: synchronous, active high; clears all valid bits. No other state.
module closest_point_on_triangle_top #(
   parameter int COORD_WIDTH = cpt_pkg::COORD_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [COORD_WIDTH-1:0] req_vertex0_x,
   input  logic signed [COORD_WIDTH-1:0] req_vertex0_y,
   input  logic signed [COORD_WIDTH-1:0] req_vertex0_z,
   input  logic signed [COORD_WIDTH-1:0] req_vertex1_x,
   input  logic signed [COORD_WIDTH-1:0] req_vertex1_y,
   input  logic signed [COORD_WIDTH-1:0] req_vertex1_z,
   input  logic signed [COORD_WIDTH-1:0] req_vertex2_x,
   input  logic signed [COORD_WIDTH-1:0] req_vertex2_y,
   input  logic signed [COORD_WIDTH-1:0] req_vertex2_z,
   input  logic signed [COORD_WIDTH-1:0] req_query_x,
   input  logic signed [COORD_WIDTH-1:0] req_query_y,
   input  logic signed [COORD_WIDTH-1:0] req_query_z,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [COORD_WIDTH-1:0] rsp_nearest_x,
   output logic signed [COORD_WIDTH-1:0] rsp_nearest_y,
   output logic signed [COORD_WIDTH-1:0] rsp_nearest_z
);

   localparam int CW  = COORD_WIDTH;
   localparam int NA  = cpt_pkg::NUM_AXES;
   localparam int W1  = 2*CW + 4;            // dot products
   localparam int W2  = 2*W1 + 1;            // det, s, t
   localparam int WU  = W2 + CW + 5;         // lifted dividend
   localparam int WD  = W2 + 1;              // divisor 2*den
   localparam int QW  = CW + 2;              // quotient bits
   localparam int WR  = CW + 4;              // final sum
   localparam int LAT = cpt_pkg::DOTS_LAT + cpt_pkg::REGION_LAT
                      + cpt_pkg::BLEND_LAT + QW;

   localparam logic signed [WR-1:0] LIFT = WR'(1) <<< (CW + 1);
   localparam logic signed [WR-1:0] MAXC = (WR'(1) <<< (CW - 1)) - WR'(1);
   localparam logic signed [WR-1:0] MINC = -MAXC - WR'(1);

   logic advance;
   logic done;

   // valid bits riding alongside the data stages
   logic [LAT-1:0] vld_ff;

   // a stall only holds the pipe once the skid entry is taken
   logic skid_vld_ff;
   logic out_vld_ff;

   assign advance   = !skid_vld_ff;
   assign req_ready = advance;
   assign done      = advance && vld_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[LAT-2:0], req_valid};
      end
   end

   // request fields as per-axis arrays
   logic signed [CW-1:0] p0 [NA];
   logic signed [CW-1:0] p1 [NA];
   logic signed [CW-1:0] p2 [NA];
   logic signed [CW-1:0] qp [NA];

   assign p0 = '{req_vertex0_x, req_vertex0_y, req_vertex0_z};
   assign p1 = '{req_vertex1_x, req_vertex1_y, req_vertex1_z};
   assign p2 = '{req_vertex2_x, req_vertex2_y, req_vertex2_z};
   assign qp = '{req_query_x, req_query_y, req_query_z};

   // edges and dot products
   logic signed [W1-1:0] dot [5];
   logic signed [CW-1:0] p0_a [NA];
   logic signed [CW:0]   e0_a [NA];
   logic signed [CW:0]   e1_a [NA];

   cpt_dots #(.COORD_WIDTH(CW)) u_dots (
      .clock(clock), .enable(advance),
      .p0(p0), .p1(p1), .p2(p2), .qp(qp),
      .dot(dot), .p0_out(p0_a), .e0_out(e0_a), .e1_out(e1_a));

   // region selection and clamped parameters
   logic signed [W2-1:0] sn, tn, den;
   logic signed [CW-1:0] p0_b [NA];
   logic signed [CW:0]   e0_b [NA];
   logic signed [CW:0]   e1_b [NA];

   cpt_region #(.COORD_WIDTH(CW)) u_region (
      .clock(clock), .enable(advance),
      .dot(dot), .p0(p0_a), .e0(e0_a), .e1(e1_a),
      .sn(sn), .tn(tn), .den(den),
      .p0_out(p0_b), .e0_out(e0_b), .e1_out(e1_b));

   // weighted sums, rounding offset
   logic [WU-1:0]        dvd [NA];
   logic [WD-1:0]        dvs;
   logic signed [CW-1:0] p0_c [NA];

   cpt_blend #(.COORD_WIDTH(CW)) u_blend (
      .clock(clock), .enable(advance),
      .sn(sn), .tn(tn), .den(den), .p0(p0_b), .e0(e0_b), .e1(e1_b),
      .dvd(dvd), .dvs(dvs), .p0_out(p0_c));

   // one divider lane per axis; vertex 0 travels as the tag
   logic [QW-1:0] quo    [NA];
   logic [CW-1:0] p0_bits [NA];
   logic [WR-1:0] sum    [NA];
   logic signed [CW-1:0] res [NA];

   for (genvar k = 0; k < NA; k++) begin : g_lane
      cpt_div #(.NW(WU), .DW(WD), .QW(QW), .TW(CW)) u_div (
         .clock(clock), .enable(advance),
         .num(dvd[k]), .den(dvs), .tag(p0_c[k]),
         .quo(quo[k]), .tag_out(p0_bits[k]));
   end

   // p0 + floor quotient minus the lift, then saturate
   always_comb begin
      for (int k = 0; k < NA; k++) begin
         sum[k] = WR'($signed(p0_bits[k])) + $signed(WR'(quo[k])) - LIFT;
         if ($signed(sum[k]) > MAXC) begin
            res[k] = CW'(MAXC);
         end else if ($signed(sum[k]) < MINC) begin
            res[k] = CW'(MINC);
         end else begin
            res[k] = CW'(sum[k]);
         end
      end
   end

   // output register plus skid entry
   logic signed [CW-1:0] out_ff  [NA];
   logic signed [CW-1:0] skid_ff [NA];

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         if (!out_vld_ff || rsp_ready) begin
            if (skid_vld_ff) begin
               out_vld_ff  <= 1'b1;
               skid_vld_ff <= 1'b0;
            end else begin
               out_vld_ff <= done;
            end
         end else if (done) begin
            skid_vld_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!out_vld_ff || rsp_ready) begin
         out_ff <= skid_vld_ff ? skid_ff : res;
      end
      if (out_vld_ff && !rsp_ready && done) begin
         skid_ff <= res;
      end
   end

   assign rsp_valid     = out_vld_ff;
   assign rsp_nearest_x = out_ff[0];
   assign rsp_nearest_y = out_ff[1];
   assign rsp_nearest_z = out_ff[2];

endmodule

FILE: design/cpt_mul.sv
// Two-stage signed multiplier built from registered partial products.
module cpt_mul #(
   parameter int WA = 52,
   parameter int WB = 52,
   parameter int CA = 2,
   parameter int CB = 2
) (
   input  logic                    clock,
   input  logic                    enable,
   input  logic signed [WA-1:0]    a,
   input  logic signed [WB-1:0]    b,
   output logic signed [WA+WB-1:0] p
);

   localparam int LA  = (WA + CA - 1) / CA;
   localparam int LB  = (WB + CB - 1) / CB;
   localparam int WP  = WA + WB;
   localparam int WPP = LA + LB + 2;

   logic signed [CA*LA-1:0] a_ext;
   logic signed [CB*LB-1:0] b_ext;
   logic signed [WPP-1:0]   pp_ff [CA][CB];
   logic signed [WP-1:0]    p_in;
   logic signed [WP-1:0]    p_ff;

   assign a_ext = (CA*LA)'(a);
   assign b_ext = (CB*LB)'(b);

   // low chunks unsigned, top chunk carries the sign
   for (genvar i = 0; i < CA; i++) begin : g_a
      for (genvar j = 0; j < CB; j++) begin : g_b
         logic signed [LA:0] opa;
         logic signed [LB:0] opb;
         if (i == CA - 1) begin : g_atop
            assign opa = {a_ext[CA*LA-1], a_ext[i*LA +: LA]};
         end else begin : g_alow
            assign opa = {1'b0, a_ext[i*LA +: LA]};
         end
         if (j == CB - 1) begin : g_btop
            assign opb = {b_ext[CB*LB-1], b_ext[j*LB +: LB]};
         end else begin : g_blow
            assign opb = {1'b0, b_ext[j*LB +: LB]};
         end
         always_ff @(posedge clock) begin
            if (enable) begin
               pp_ff[i][j] <= opa * opb;
            end
         end
      end
   end

   always_comb begin
      p_in = '0;
      for (int i = 0; i < CA; i++) begin
         for (int j = 0; j < CB; j++) begin
            p_in = p_in + (WP'(pp_ff[i][j]) <<< (i*LA + j*LB));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         p_ff <= p_in;
      end
   end

   assign p = p_ff;

endmodule

FILE: design/cpt_dots.sv
// Edge vectors and the five dot products a, b, c, d, e.
module cpt_dots #(
   parameter int COORD_WIDTH = cpt_pkg::COORD_WIDTH
) (
   input  logic                          clock,
   input  logic                          enable,
   input  logic signed [COORD_WIDTH-1:0] p0   [cpt_pkg::NUM_AXES],
   input  logic signed [COORD_WIDTH-1:0] p1   [cpt_pkg::NUM_AXES],
   input  logic signed [COORD_WIDTH-1:0] p2   [cpt_pkg::NUM_AXES],
   input  logic signed [COORD_WIDTH-1:0] qp   [cpt_pkg::NUM_AXES],
   output logic signed [2*COORD_WIDTH+3:0] dot [5],
   output logic signed [COORD_WIDTH-1:0] p0_out [cpt_pkg::NUM_AXES],
   output logic signed [COORD_WIDTH:0]   e0_out [cpt_pkg::NUM_AXES],
   output logic signed [COORD_WIDTH:0]   e1_out [cpt_pkg::NUM_AXES]
);

   localparam int D  = COORD_WIDTH + 1;
   localparam int W1 = 2*D + 2;
   localparam int NA = cpt_pkg::NUM_AXES;

   logic signed [COORD_WIDTH-1:0] p0_ff [3][NA];
   logic signed [D-1:0]           e0_ff [3][NA];
   logic signed [D-1:0]           e1_ff [3][NA];
   logic signed [D-1:0]           v_ff  [NA];
   logic signed [2*D-1:0]         pr_ff [5][NA];
   logic signed [W1-1:0]          dot_in [5];
   logic signed [W1-1:0]          dot_ff [5];

   // stage 1: differences; side data delay line
   always_ff @(posedge clock) begin
      if (enable) begin
         for (int k = 0; k < NA; k++) begin
            p0_ff[0][k] <= p0[k];
            e0_ff[0][k] <= D'(p1[k]) - D'(p0[k]);
            e1_ff[0][k] <= D'(p2[k]) - D'(p0[k]);
            v_ff[k]     <= D'(p0[k]) - D'(qp[k]);
         end
         for (int s = 1; s < 3; s++) begin
            p0_ff[s] <= p0_ff[s-1];
            e0_ff[s] <= e0_ff[s-1];
            e1_ff[s] <= e1_ff[s-1];
         end
      end
   end

   // stage 2: per-axis products; order a, b, c, d, e
   always_ff @(posedge clock) begin
      if (enable) begin
         for (int k = 0; k < NA; k++) begin
            pr_ff[0][k] <= e0_ff[0][k] * e0_ff[0][k];
            pr_ff[1][k] <= e0_ff[0][k] * e1_ff[0][k];
            pr_ff[2][k] <= e1_ff[0][k] * e1_ff[0][k];
            pr_ff[3][k] <= e0_ff[0][k] * v_ff[k];
            pr_ff[4][k] <= e1_ff[0][k] * v_ff[k];
         end
      end
   end

   // stage 3: sums over the axes
   always_comb begin
      for (int n = 0; n < 5; n++) begin
         dot_in[n] = '0;
         for (int k = 0; k < NA; k++) begin
            dot_in[n] = dot_in[n] + W1'(pr_ff[n][k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         dot_ff <= dot_in;
      end
   end

   assign dot    = dot_ff;
   assign p0_out = p0_ff[2];
   assign e0_out = e0_ff[2];
   assign e1_out = e1_ff[2];

endmodule

FILE: design/cpt_region.sv
// Determinant, barycentric numerators, region split and clamped parameters.
module cpt_region #(
   parameter int COORD_WIDTH = cpt_pkg::COORD_WIDTH
) (
   input  logic                            clock,
   input  logic                            enable,
   input  logic signed [2*COORD_WIDTH+3:0] dot   [5],
   input  logic signed [COORD_WIDTH-1:0]   p0    [cpt_pkg::NUM_AXES],
   input  logic signed [COORD_WIDTH:0]     e0    [cpt_pkg::NUM_AXES],
   input  logic signed [COORD_WIDTH:0]     e1    [cpt_pkg::NUM_AXES],
   output logic signed [4*COORD_WIDTH+8:0] sn,
   output logic signed [4*COORD_WIDTH+8:0] tn,
   output logic signed [4*COORD_WIDTH+8:0] den,
   output logic signed [COORD_WIDTH-1:0]   p0_out [cpt_pkg::NUM_AXES],
   output logic signed [COORD_WIDTH:0]     e0_out [cpt_pkg::NUM_AXES],
   output logic signed [COORD_WIDTH:0]     e1_out [cpt_pkg::NUM_AXES]
);

   localparam int W1 = 2*COORD_WIDTH + 4;
   localparam int W2 = 2*W1 + 1;
   localparam int WP = 2*W1;
   localparam int WH = W1 + 2;
   localparam int CM = (W1 + 31) / 32;
   localparam int ML = cpt_pkg::MUL_LAT;
   localparam int RL = cpt_pkg::REGION_LAT;
   localparam int NA = cpt_pkg::NUM_AXES;

   // side data delay
   logic signed [COORD_WIDTH-1:0] p0_ff [RL][NA];
   logic signed [COORD_WIDTH:0]   e0_ff [RL][NA];
   logic signed [COORD_WIDTH:0]   e1_ff [RL][NA];

   always_ff @(posedge clock) begin
      if (enable) begin
         p0_ff[0] <= p0;
         e0_ff[0] <= e0;
         e1_ff[0] <= e1;
         for (int s = 1; s < RL; s++) begin
            p0_ff[s] <= p0_ff[s-1];
            e0_ff[s] <= e0_ff[s-1];
            e1_ff[s] <= e1_ff[s-1];
         end
      end
   end

   assign p0_out = p0_ff[RL-1];
   assign e0_out = e0_ff[RL-1];
   assign e1_out = e1_ff[RL-1];

   // stages 4-5: cross products of the dots
   logic signed [WP-1:0] ac, bb, be, cd, bd, ae;

   cpt_mul #(.WA(W1), .WB(W1), .CA(CM), .CB(CM)) u_mul_ac (
      .clock(clock), .enable(enable), .a(dot[0]), .b(dot[2]), .p(ac));
   cpt_mul #(.WA(W1), .WB(W1), .CA(CM), .CB(CM)) u_mul_bb (
      .clock(clock), .enable(enable), .a(dot[1]), .b(dot[1]), .p(bb));
   cpt_mul #(.WA(W1), .WB(W1), .CA(CM), .CB(CM)) u_mul_be (
      .clock(clock), .enable(enable), .a(dot[1]), .b(dot[4]), .p(be));
   cpt_mul #(.WA(W1), .WB(W1), .CA(CM), .CB(CM)) u_mul_cd (
      .clock(clock), .enable(enable), .a(dot[2]), .b(dot[3]), .p(cd));
   cpt_mul #(.WA(W1), .WB(W1), .CA(CM), .CB(CM)) u_mul_bd (
      .clock(clock), .enable(enable), .a(dot[1]), .b(dot[3]), .p(bd));
   cpt_mul #(.WA(W1), .WB(W1), .CA(CM), .CB(CM)) u_mul_ae (
      .clock(clock), .enable(enable), .a(dot[0]), .b(dot[4]), .p(ae));

   logic signed [W1-1:0] dot_ff [ML][5];

   always_ff @(posedge clock) begin
      if (enable) begin
         dot_ff[0] <= dot;
         for (int s = 1; s < ML; s++) begin
            dot_ff[s] <= dot_ff[s-1];
         end
      end
   end

   // stage 6
   logic signed [W1-1:0] da, db, dc, dd, de;
   logic signed [W2-1:0] det_ff, s_ff, t_ff;
   logic signed [WH-1:0] hnum_ff, hyp_ff;
   logic signed [W1:0]   negd_ff, nege_ff;
   logic signed [W1-1:0] a6_ff, c6_ff;
   logic                 adle_ff, dneg_ff;

   assign da = dot_ff[ML-1][0];
   assign db = dot_ff[ML-1][1];
   assign dc = dot_ff[ML-1][2];
   assign dd = dot_ff[ML-1][3];
   assign de = dot_ff[ML-1][4];

   always_ff @(posedge clock) begin
      if (enable) begin
         det_ff  <= W2'(ac) - W2'(bb);
         s_ff    <= W2'(be) - W2'(cd);
         t_ff    <= W2'(bd) - W2'(ae);
         hnum_ff <= (WH'(dc) + WH'(de)) - (WH'(db) + WH'(dd));
         hyp_ff  <= WH'(da) - (WH'(db) <<< 1) + WH'(dc);
         negd_ff <= -(W1+1)'(dd);
         nege_ff <= -(W1+1)'(de);
         adle_ff <= (WH'(da) + WH'(dd)) <= (WH'(db) + WH'(de));
         dneg_ff <= dd[W1-1];
         a6_ff   <= da;
         c6_ff   <= dc;
      end
   end

   // stage 7: region split
   logic signed [W2:0]     st_sum;
   logic                   in_tri, sneg, tneg, hpos;
   cpt_pkg::region_type    mode_in, mode_ff;
   logic signed [W2-1:0]   cnum_in, cden_in, cnum_ff, cden_ff, tint_ff;

   assign st_sum = (W2+1)'(s_ff) + (W2+1)'(t_ff);
   assign in_tri = st_sum < (W2+1)'(det_ff);
   assign sneg   = s_ff[W2-1];
   assign tneg   = t_ff[W2-1];
   assign hpos   = !hnum_ff[WH-1] && (hnum_ff != '0);

   always_comb begin
      if (in_tri) begin
         if (sneg) begin
            mode_in = (tneg && dneg_ff) ? cpt_pkg::RGN_S_EDGE : cpt_pkg::RGN_T_EDGE;
         end else if (tneg) begin
            mode_in = cpt_pkg::RGN_S_EDGE;
         end else begin
            mode_in = cpt_pkg::RGN_INNER;
         end
      end else begin
         if (sneg) begin
            mode_in = hpos ? cpt_pkg::RGN_HYP : cpt_pkg::RGN_T_EDGE;
         end else if (tneg && adle_ff) begin
            mode_in = cpt_pkg::RGN_S_EDGE;
         end else begin
            mode_in = cpt_pkg::RGN_HYP;
         end
      end
   end

   always_comb begin
      case (mode_in)
         cpt_pkg::RGN_INNER: begin
            cnum_in = s_ff;
            cden_in = det_ff;
         end
         cpt_pkg::RGN_S_EDGE: begin
            cnum_in = W2'(negd_ff);
            cden_in = W2'(a6_ff);
         end
         cpt_pkg::RGN_T_EDGE: begin
            cnum_in = W2'(nege_ff);
            cden_in = W2'(c6_ff);
         end
         default: begin
            cnum_in = W2'(hnum_ff);
            cden_in = W2'(hyp_ff);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         mode_ff <= mode_in;
         cnum_ff <= cnum_in;
         cden_ff <= cden_in;
         tint_ff <= t_ff;
      end
   end

   // stage 8: clamp to [0, 1] outside the inner region
   logic signed [W2-1:0] cn, cdn, sn_in, tn_in, den_in;

   always_comb begin
      if (cden_ff[W2-1] || cden_ff == '0 || cnum_ff[W2-1] || cnum_ff == '0) begin
         cn  = '0;
         cdn = W2'(1);
      end else if (cnum_ff >= cden_ff) begin
         cn  = W2'(1);
         cdn = W2'(1);
      end else begin
         cn  = cnum_ff;
         cdn = cden_ff;
      end
   end

   always_comb begin
      case (mode_ff)
         cpt_pkg::RGN_INNER: begin
            sn_in  = cnum_ff;
            tn_in  = tint_ff;
            den_in = cden_ff;
         end
         cpt_pkg::RGN_S_EDGE: begin
            sn_in  = cn;
            tn_in  = '0;
            den_in = cdn;
         end
         cpt_pkg::RGN_T_EDGE: begin
            sn_in  = '0;
            tn_in  = cn;
            den_in = cdn;
         end
         default: begin
            sn_in  = cn;
            tn_in  = cdn - cn;
            den_in = cdn;
         end
      endcase
   end

   logic signed [W2-1:0] sn_ff, tn_ff, den_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         sn_ff  <= sn_in;
         tn_ff  <= tn_in;
         den_ff <= den_in;
      end
   end

   assign sn  = sn_ff;
   assign tn  = tn_ff;
   assign den = den_ff;

endmodule

FILE: design/cpt_blend.sv
// Weighted edge sums and the offset dividend for the rounding divide.
module cpt_blend #(
   parameter int COORD_WIDTH = cpt_pkg::COORD_WIDTH
) (
   input  logic                            clock,
   input  logic                            enable,
   input  logic signed [4*COORD_WIDTH+8:0] sn,
   input  logic signed [4*COORD_WIDTH+8:0] tn,
   input  logic signed [4*COORD_WIDTH+8:0] den,
   input  logic signed [COORD_WIDTH-1:0]   p0     [cpt_pkg::NUM_AXES],
   input  logic signed [COORD_WIDTH:0]     e0     [cpt_pkg::NUM_AXES],
   input  logic signed [COORD_WIDTH:0]     e1     [cpt_pkg::NUM_AXES],
   output logic        [5*COORD_WIDTH+13:0] dvd   [cpt_pkg::NUM_AXES],
   output logic        [4*COORD_WIDTH+9:0] dvs,
   output logic signed [COORD_WIDTH-1:0]   p0_out [cpt_pkg::NUM_AXES]
);

   localparam int D  = COORD_WIDTH + 1;
   localparam int W2 = 4*COORD_WIDTH + 9;
   localparam int WP = W2 + D;
   localparam int W3 = WP + 1;
   localparam int WU = W2 + COORD_WIDTH + 5;
   localparam int WD = W2 + 1;
   localparam int CS = (W2 + 31) / 32;
   localparam int ML = cpt_pkg::MUL_LAT;
   localparam int NA = cpt_pkg::NUM_AXES;

   logic signed [WP-1:0] ps [NA];
   logic signed [WP-1:0] pt [NA];

   for (genvar k = 0; k < NA; k++) begin : g_axis
      cpt_mul #(.WA(W2), .WB(D), .CA(CS), .CB(1)) u_mul_s (
         .clock(clock), .enable(enable), .a(sn), .b(e0[k]), .p(ps[k]));
      cpt_mul #(.WA(W2), .WB(D), .CA(CS), .CB(1)) u_mul_t (
         .clock(clock), .enable(enable), .a(tn), .b(e1[k]), .p(pt[k]));
   end

   logic signed [W2-1:0]          den_ff [ML];
   logic signed [COORD_WIDTH-1:0] p0_ff  [ML+1][NA];

   always_ff @(posedge clock) begin
      if (enable) begin
         den_ff[0] <= den;
         p0_ff[0]  <= p0;
         for (int s = 1; s < ML; s++) begin
            den_ff[s] <= den_ff[s-1];
         end
         for (int s = 1; s <= ML; s++) begin
            p0_ff[s] <= p0_ff[s-1];
         end
      end
   end

   // 2*num + den, lifted by den * 2^(CW+2) so the divide sees a positive value
   logic signed [W3-1:0] num   [NA];
   logic signed [WU-1:0] shift [NA];
   logic [WU-1:0]        dvd_ff [NA];
   logic [WD-1:0]        dvs_ff;

   always_comb begin
      for (int k = 0; k < NA; k++) begin
         num[k]   = W3'(ps[k]) + W3'(pt[k]);
         shift[k] = (WU'(num[k]) <<< 1) + WU'(den_ff[ML-1])
                  + (WU'(den_ff[ML-1]) <<< (COORD_WIDTH + 2));
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int k = 0; k < NA; k++) begin
            dvd_ff[k] <= shift[k];
         end
         dvs_ff <= {den_ff[ML-1], 1'b0};
      end
   end

   assign dvd    = dvd_ff;
   assign dvs    = dvs_ff;
   assign p0_out = p0_ff[ML];

endmodule

FILE: design/cpt_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module cpt_div #(
   parameter int NW = 134,
   parameter int DW = 106,
   parameter int QW = 26,
   parameter int TW = 24
) (
   input  logic          clock,
   input  logic          enable,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   input  logic [TW-1:0] tag,
   output logic [QW-1:0] quo,
   output logic [TW-1:0] tag_out
);

   logic [DW-1:0] rem_ff [QW];
   logic [QW-1:0] low_ff [QW];
   logic [QW-1:0] quo_ff [QW];
   logic [DW-1:0] den_ff [QW];
   logic [TW-1:0] tag_ff [QW];

   for (genvar i = 0; i < QW; i++) begin : g_step
      logic [DW-1:0] rem_q, den_q;
      logic [QW-1:0] low_q, quo_q;
      logic [TW-1:0] tag_q;
      logic [DW:0]   shifted;
      logic          ge;

      if (i == 0) begin : g_first
         // quotient fits QW bits, so the upper dividend part is below den
         assign rem_q = num[QW +: DW];
         assign low_q = num[QW-1:0];
         assign quo_q = '0;
         assign den_q = den;
         assign tag_q = tag;
      end else begin : g_next
         assign rem_q = rem_ff[i-1];
         assign low_q = low_ff[i-1];
         assign quo_q = quo_ff[i-1];
         assign den_q = den_ff[i-1];
         assign tag_q = tag_ff[i-1];
      end

      assign shifted = {rem_q, low_q[QW-1-i]};
      assign ge      = shifted >= {1'b0, den_q};

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[i] <= ge ? DW'(shifted - {1'b0, den_q}) : DW'(shifted);
            low_ff[i] <= low_q;
            quo_ff[i] <= {quo_q[QW-2:0], ge};
            den_ff[i] <= den_q;
            tag_ff[i] <= tag_q;
         end
      end
   end

   assign quo     = quo_ff[QW-1];
   assign tag_out = tag_ff[QW-1];

endmodule

FILE: design/cpt_checker.sv
// Port-level checks for the closest point block, bound to its top level.
`include "closest_point_on_triangle_top_defines.svh"

module cpt_checker #(
   parameter int COORD_WIDTH = cpt_pkg::COORD_WIDTH
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [COORD_WIDTH-1:0] rsp_nearest_x,
   input logic [COORD_WIDTH-1:0] rsp_nearest_y,
   input logic [COORD_WIDTH-1:0] rsp_nearest_z
);

   `CPT_ASSERT_RESET(a_reset_clears, !rsp_valid && req_ready, "reset left output or skid full")

   `CPT_ASSERT(a_full_needs_rsp, !req_ready |-> rsp_valid, "backpressure with no result shown")

   `CPT_ASSERT(a_full_holds, !req_ready && !rsp_ready |=> !req_ready, "skid drained while stalled")

   `CPT_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_nearest_x) && $stable(rsp_nearest_y) && $stable(rsp_nearest_z), "result changed while stalled")

endmodule

bind closest_point_on_triangle_top cpt_checker #(.COORD_WIDTH(COORD_WIDTH)) u_cpt_checker (
   .clock(clock),
   .reset(reset),
   .req_ready(req_ready),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_nearest_x(rsp_nearest_x),
   .rsp_nearest_y(rsp_nearest_y),
   .rsp_nearest_z(rsp_nearest_z)
);

FILE: test/tb_closest_point_on_triangle_top.sv
// Self-checking testbench of closest_point_on_triangle_top: streams triangles, checks results.
module tb_closest_point_on_triangle_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int COORD_WIDTH = cpt_pkg::COORD_WIDTH;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   // wide enough for every intermediate product of the predictor
   typedef logic signed [255:0] big_type;
   typedef struct {
      coord_type x;
      coord_type y;
      coord_type z;
   } point_type;

   localparam int  TAIL_CYCLES  = COORD_WIDTH + 40;
   localparam int  CYCLE_LIMIT  = 400000;
   localparam int  RANDOM_ITEMS = 1150;
   localparam int  QUIET_ITEMS  = 150;

   // Expected nearest points, oldest first; holds its own predictor.
   class nearest_point_board;
      point_type pending[$];
      int        errors = 0;

      static function big_type dot3(big_type x[3], big_type y[3]);
         return x[0] * y[0] + x[1] * y[1] + x[2] * y[2];
      endfunction

      // clamp(num/den, 0, 1) as a fraction; bad divisor gives 0
      static function void clamp_unit(big_type num, big_type den, output big_type n,
                                      output big_type dn);
         if (den <= 0 || num <= 0) begin
            n = 0;
            dn = 1;
         end else if (num >= den) begin
            n = 1;
            dn = 1;
         end else begin
            n = num;
            dn = den;
         end
      endfunction

      static function point_type nearest_point(coord_type f[12]);
         big_type   p0[3], e0[3], e1[3], v[3];
         big_type   a, b, c, d, e, det, s, t, sn, tn, den, pn, pd, hyp, t0, t1;
         big_type   num, n2, dd, q, r;
         big_type   maxc, minc;
         coord_type res[3];
         point_type pt;
         maxc = (big_type'(1) <<< (COORD_WIDTH - 1)) - 1;
         minc = -maxc - 1;
         for (int k = 0; k < 3; k++) begin
            p0[k] = big_type'(f[k]);
            e0[k] = big_type'(f[3 + k]) - p0[k];
            e1[k] = big_type'(f[6 + k]) - p0[k];
            v[k]  = p0[k] - big_type'(f[9 + k]);
         end
         a = dot3(e0, e0);
         b = dot3(e0, e1);
         c = dot3(e1, e1);
         d = dot3(e0, v);
         e = dot3(e1, v);
         det = a * c - b * b;
         s = b * e - c * d;
         t = b * d - a * e;
         if (s + t < det) begin
            if (s < 0) begin
               if (t < 0 && d < 0) begin
                  clamp_unit(-d, a, pn, pd);
                  sn = pn; tn = 0; den = pd;
               end else begin
                  clamp_unit(-e, c, pn, pd);
                  sn = 0; tn = pn; den = pd;
               end
            end else if (t < 0) begin
               clamp_unit(-d, a, pn, pd);
               sn = pn; tn = 0; den = pd;
            end else begin
               sn = s; tn = t; den = det;
            end
         end else begin
            hyp = a - 2 * b + c;
            if (s < 0) begin
               t0 = b + d;
               t1 = c + e;
               if (t1 > t0) begin
                  clamp_unit(t1 - t0, hyp, pn, pd);
                  sn = pn; tn = pd - pn; den = pd;
               end else begin
                  clamp_unit(-e, c, pn, pd);
                  sn = 0; tn = pn; den = pd;
               end
            end else if (t < 0 && a + d <= b + e) begin
               clamp_unit(-d, a, pn, pd);
               sn = pn; tn = 0; den = pd;
            end else begin
               clamp_unit((c + e) - (b + d), hyp, pn, pd);
               sn = pn; tn = pd - pn; den = pd;
            end
         end
         for (int k = 0; k < 3; k++) begin
            num = sn * e0[k] + tn * e1[k];
            n2 = 2 * num + den;
            dd = 2 * den;
            q = n2 / dd;
            if (n2 < 0 && q * dd != n2) q = q - 1; // floor, not truncation
            r = p0[k] + q;
            if (r > maxc) r = maxc;
            if (r < minc) r = minc;
            res[k] = r[COORD_WIDTH-1:0];
         end
         pt.x = res[0];
         pt.y = res[1];
         pt.z = res[2];
         return pt;
      endfunction

      function void note_request(coord_type f[12]);
         pending.push_back(nearest_point(f));
      endfunction

      function void check_result(point_type got);
         point_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result (%0d, %0d, %0d)", $time, got.x, got.y, got.z);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.x !== want.x) begin
            $display("%0t: nearest_x expected %0d actual %0d", $time, want.x, got.x);
            errors++;
         end
         if (got.y !== want.y) begin
            $display("%0t: nearest_y expected %0d actual %0d", $time, want.y, got.y);
            errors++;
         end
         if (got.z !== want.z) begin
            $display("%0t: nearest_z expected %0d actual %0d", $time, want.z, got.z);
            errors++;
         end
      endfunction
   endclass

   logic      clock;
   logic      reset;
   logic      req_valid;
   logic      req_ready;
   coord_type req_field[12];
   logic      rsp_valid;
   logic      rsp_ready;
   coord_type rsp_nearest_x;
   coord_type rsp_nearest_y;
   coord_type rsp_nearest_z;

   nearest_point_board board = new();
   bit     quiet = 0;   // no idling on either side when set
   int     cycles = 0;

   closest_point_on_triangle_top i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_vertex0_x (req_field[0]),
      .req_vertex0_y (req_field[1]),
      .req_vertex0_z (req_field[2]),
      .req_vertex1_x (req_field[3]),
      .req_vertex1_y (req_field[4]),
      .req_vertex1_z (req_field[5]),
      .req_vertex2_x (req_field[6]),
      .req_vertex2_y (req_field[7]),
      .req_vertex2_z (req_field[8]),
      .req_query_x   (req_field[9]),
      .req_query_y   (req_field[10]),
      .req_query_z   (req_field[11]),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_nearest_x (rsp_nearest_x),
      .rsp_nearest_y (rsp_nearest_y),
      .rsp_nearest_z (rsp_nearest_z)
   );

   // 2 ns clock
   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // Watchdog: a hang never reaches the final verdict otherwise.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("closest_point_on_triangle_top verification failed");
         $finish;
      end
   end

   // Result side: every rsp_ transfer is checked against the oldest expectation.
   always @(posedge clock) begin
      point_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.x = rsp_nearest_x;
         got.y = rsp_nearest_y;
         got.z = rsp_nearest_z;
         board.check_result(got);
      end
   end

   // Receiver back-pressure: random stall bursts, none when quiet.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!quiet && $urandom_range(0, 9) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(0, 11)) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // One req_ transfer. Called just after a rising edge; payload changes at the
   // falling edge, and valid stays high into the next item unless a gap is taken.
   task automatic send_item(coord_type f[12]);
      @(negedge clock);
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
      for (int k = 0; k < 12; k++) req_field[k] <= f[k];
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      board.note_request(f);
   endtask

   task automatic send_points(int ax, int ay, int az, int bx, int by, int bz,
                              int cx, int cy, int cz, int qx, int qy, int qz);
      coord_type f[12];
      f = '{coord_type'(ax), coord_type'(ay), coord_type'(az), coord_type'(bx),
            coord_type'(by), coord_type'(bz), coord_type'(cx), coord_type'(cy),
            coord_type'(cz), coord_type'(qx), coord_type'(qy), coord_type'(qz)};
      send_item(f);
   endtask

   // Drop valid and hold the sender until every expected result is back.
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
   endtask

   function automatic coord_type near_coord(coord_type base, int span);
      return coord_type'(int'(base) + $urandom_range(0, 2 * span) - span);
   endfunction

   task automatic send_random_item();
      coord_type f[12];
      int        span;
      int        shape;
      shape = $urandom_range(0, 9);
      span  = 1 << $urandom_range(2, 16);
      for (int k = 0; k < 12; k++) f[k] = coord_type'($urandom);
      case (shape)
         0, 1: ; // full-range noise, toggles every bit
         2: begin
            // vertex 1 on or near vertex 0; vertex 2 copies each axis from vertex 0 or 1
            for (int k = 0; k < 3; k++) begin
               f[3 + k] = ($urandom_range(0, 1) != 0) ? f[k] : near_coord(f[k], span);
               f[6 + k] = ($urandom_range(0, 1) != 0) ? f[3 + k] : f[k];
            end
         end
         3: begin
            for (int k = 0; k < 12; k++) f[k] = coord_type'($urandom_range(0, 2047) - 1024);
         end
         default: begin
            // compact triangle with the query nearby
            for (int k = 0; k < 3; k++) begin
               f[3 + k] = near_coord(f[k], span);
               f[6 + k] = near_coord(f[k], span);
               f[9 + k] = near_coord(f[k], 2 * span);
            end
         end
      endcase
      send_item(f);
   endtask

   localparam int MAXC = (1 << (COORD_WIDTH - 1)) - 1;
   localparam int MINC = -MAXC - 1;

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      for (int k = 0; k < 12; k++) req_field[k] = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: one item per region, degenerate shapes, coordinate extremes
      send_points(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      send_points(0, 0, 0, 2560, 0, 0, 0, 2560, 0, 512, 512, 700);     // interior
      send_points(0, 0, 0, 2560, 0, 0, 0, 2560, 0, -500, -500, 0);     // vertex 0
      send_points(0, 0, 0, 2560, 0, 0, 0, 2560, 0, 1000, -500, 0);     // s edge
      send_points(0, 0, 0, 2560, 0, 0, 0, 2560, 0, -500, 1000, 0);     // t edge
      send_points(0, 0, 0, 2560, 0, 0, 0, 2560, 0, 4000, -300, 0);     // vertex 1
      send_points(0, 0, 0, 2560, 0, 0, 0, 2560, 0, -300, 4000, 100);   // vertex 2
      send_points(0, 0, 0, 2560, 0, 0, 0, 2560, 0, 2000, 2000, -50);   // hypotenuse
      send_points(0, 0, 0, 2560, 0, 0, 0, 2560, 0, 3000, 100, 9);      // hyp near vertex 1
      send_points(100, 200, 300, 100, 200, 300, 100, 200, 300, -7, 55, 900); // point
      send_points(100, 200, 300, 100, 200, 300, 900, -40, 7, 500, 500, 500); // first edge zero
      send_points(100, 200, 300, 900, -40, 7, 100, 200, 300, 500, 500, 500); // edge e1 zero (vertex 2 on vertex 0)
      send_points(100, 200, 300, 900, -40, 7, 900, -40, 7, 700, 0, 0);       // hyp zero
      send_points(0, 0, 0, 1000, 1000, 0, 2000, 2000, 0, 1500, 0, 77);       // collinear
      send_points(MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MINC, MINC, MINC);
      send_points(MINC, MINC, MINC, MAXC, MINC, MINC, MINC, MAXC, MINC, MAXC, MAXC, MAXC);
      send_points(MAXC, MAXC, MAXC, MINC, MAXC, MAXC, MAXC, MINC, MAXC, MINC, MINC, MINC);
      send_points(MINC, MAXC, MINC, MAXC, MINC, MAXC, MINC, MINC, MAXC, 0, 0, 0);
      send_points(MAXC, MINC, MAXC, MINC, MAXC, MINC, MAXC, MAXC, MINC, -1, -1, -1);
      send_points(1, 0, 0, 0, 1, 0, 0, 0, 1, 1, 1, 1);                       // nearest point in thirds, rounded

      // hold off until the pipeline is empty, then restart from idle
      drain_results();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS - QUIET_ITEMS) quiet = 1;
         send_random_item();
         if (n == RANDOM_ITEMS / 2) drain_results();
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("closest_point_on_triangle_top verification clean");
      end else begin
         $display("closest_point_on_triangle_top verification failed");
      end
      $finish;
   end

endmodule
